@@ design/hla_pkg.sv @@
// Hough line accumulator: shared constants, types and the trig table.
// No dependencies; used by every module of the block but hla_ram.
`default_nettype none
package hla_pkg;
  localparam int ANGLES_DEF = 36;
  localparam int RADII_DEF = 1024;
  localparam int TRIG_SCALE_DEF = 65536;
  localparam int SCALE_BITS = 16;
  localparam int CNT_W = 16;
  localparam int SUM_W = 27;
  localparam int POS_W = 11;
  localparam int THR_W = 17;
  localparam int TRIG_W = 18;
  localparam int CELL_W = CNT_W + SUM_W + 2 * POS_W;
  localparam logic [THR_W-1:0] THRESH_RESET = 17'd46341;
  localparam logic signed [POS_W-1:0] POS_MIN_INIT = 11'sd1023;
  localparam logic signed [POS_W-1:0] POS_MAX_INIT = -11'sd1024;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_HORIZ = 2'd1,
    MODE_VERT  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLEAR,
    ST_VOTE,
    ST_REPORT
  } state_t;

  // token handed from cell to cell along the angle chain
  typedef struct packed {
    logic        vld;
    logic        clr;
    logic        vert;
    logic [8:0]  row;
    logic [8:0]  col;
  } tok_t;

  // cos/sin of 2*pi*a/36 scaled by 65536, truncated toward zero
  function automatic logic signed [TRIG_W-1:0] trig_cos(input int a);
    logic signed [TRIG_W-1:0] t [0:9];
    int k;
    int q;
    logic signed [TRIG_W-1:0] v;
    begin
      t[0] = 18'sd65536; t[1] = 18'sd64540; t[2] = 18'sd61583;
      t[3] = 18'sd56755; t[4] = 18'sd50203; t[5] = 18'sd42125;
      t[6] = 18'sd32768; t[7] = 18'sd22414; t[8] = 18'sd11380;
      t[9] = 18'sd0;
      k = a % 36;
      q = k / 9;
      case (q)
        0: v = t[k];
        1: v = -t[18 - k];
        2: v = -t[k - 18];
        default: v = t[36 - k];
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [TRIG_W-1:0] trig_sin(input int a);
    return trig_cos(a + 27);
  endfunction
endpackage
`default_nettype wire

@@ design/hla_ram.sv @@
// Generic dual-port RAM: one write and one registered read a cycle.
// No dependencies.
`default_nettype none
module hla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/hla_cell.sv @@
// One angle cell: trig constants, radius/position, row RAM read-modify-write.
// Depends on hla_pkg and hla_ram.
`default_nettype none
module hla_cell #(
  parameter int ANGLE = 0,
  parameter int RADII = hla_pkg::RADII_DEF,
  parameter int RAD_W = $clog2(RADII)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [hla_pkg::THR_W-1:0] thresh,
  input  wire hla_pkg::tok_t             tok_in,
  output hla_pkg::tok_t                  tok_out,
  // vote outcome of this cell, valid while tok_out holds the same token
  output logic                           hit,
  output logic [hla_pkg::CNT_W-1:0]      hit_count,
  output logic [RAD_W-1:0]               hit_radius,
  // report read port
  input  wire logic [RAD_W-1:0]          rep_addr,
  output logic [hla_pkg::CELL_W-1:0]     rep_data
);
  localparam logic signed [hla_pkg::TRIG_W-1:0] C = hla_pkg::trig_cos(ANGLE);
  localparam logic signed [hla_pkg::TRIG_W-1:0] S = hla_pkg::trig_sin(ANGLE);
  localparam int PW = 30;

  logic [hla_pkg::THR_W-1:0] mag;
  logic signed [PW-1:0] rad_prod, pos_prod, rad_q, pos_q;
  logic signed [PW-1:0] ri, rj;
  logic go, go_d;
  logic [RAD_W-1:0] r_d;
  logic signed [hla_pkg::POS_W-1:0] pos_d;
  logic [RAD_W:0] clr_addr;
  logic clr_run;
  logic [RAD_W-1:0] raddr, waddr;
  logic we;
  logic [hla_pkg::CELL_W-1:0] wdata, rdata;
  logic [hla_pkg::CNT_W-1:0] cnt, cnt_next;
  logic signed [hla_pkg::SUM_W-1:0] sum;
  logic signed [hla_pkg::POS_W-1:0] pmin, pmax;
  logic valid_cell;

  always_comb begin
    mag = tok_in.vert ? hla_pkg::THR_W'(C < 0 ? -C : C)
                      : hla_pkg::THR_W'(S < 0 ? -S : S);
    ri = PW'(tok_in.row);
    rj = PW'(tok_in.col);
    rad_prod = PW'(C) * ri + PW'(S) * rj;
    pos_prod = PW'(C) * rj - PW'(S) * ri;
    // truncate toward zero
    rad_q = (rad_prod + (rad_prod < 0 ? PW'(65535) : PW'(0))) >>> hla_pkg::SCALE_BITS;
    pos_q = (pos_prod + (pos_prod < 0 ? PW'(65535) : PW'(0))) >>> hla_pkg::SCALE_BITS;
    go = tok_in.vld && !tok_in.clr && mag >= thresh && rad_q >= 0 && rad_q < RADII;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      go_d <= 1'b0;
      clr_run <= 1'b1;
      clr_addr <= '0;
    end else begin
      tok_out <= tok_in;
      go_d <= go;
      if (tok_in.vld && tok_in.clr) begin
        clr_run <= 1'b1;
        clr_addr <= '0;
      end else if (clr_run) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == (RAD_W+1)'(RADII - 1)) begin
          clr_run <= 1'b0;
        end
      end
    end
    r_d <= rad_q[RAD_W-1:0];
    pos_d <= pos_q[hla_pkg::POS_W-1:0];
  end

  assign raddr = go ? rad_q[RAD_W-1:0] : rep_addr;
  assign {cnt, sum, pmin, pmax} = rdata;
  assign valid_cell = (cnt != {hla_pkg::CNT_W{1'b1}});
  assign cnt_next = cnt + 1'b1;

  always_comb begin
    we = 1'b0;
    waddr = r_d;
    wdata = rdata;
    if (clr_run) begin
      we = 1'b1;
      waddr = clr_addr[RAD_W-1:0];
      wdata = {{hla_pkg::CNT_W{1'b0}}, {hla_pkg::SUM_W{1'b0}},
               hla_pkg::POS_MIN_INIT, hla_pkg::POS_MAX_INIT};
    end else if (go_d && valid_cell) begin
      we = 1'b1;
      wdata = {cnt_next, sum + hla_pkg::SUM_W'(pos_d),
               (pos_d < pmin) ? pos_d : pmin, (pos_d > pmax) ? pos_d : pmax};
    end
  end

  assign hit = go_d && valid_cell && !clr_run;
  assign hit_count = cnt_next;
  assign hit_radius = r_d;
  assign rep_data = rdata;

  hla_ram #(.WIDTH(hla_pkg::CELL_W), .DEPTH(RADII)) u_row (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
endmodule
`default_nettype wire

@@ design/hough_line_accumulator.sv @@
// Top level: sequencer, chain of angle cells, best-cell tracking.
// Depends on hla_pkg, hla_cell, hla_ram.
// Sequence: pixel and mode 3 go to ST_VOTE, clear goes to ST_CLEAR, then ST_REPORT and the
// result strobe; each cell clears its row once the clear token reaches it, one entry a cycle.
// Throughput: one item at a time; the token walks the cell chain one angle a cycle.
// Reset clears every cell at once and holds busy in ST_INIT, with no result beat.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module hough_line_accumulator #(
  parameter int RADII = hla_pkg::RADII_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        mode,
  input  wire logic [8:0]                        pixel_row,
  input  wire logic [8:0]                        pixel_col,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hla_pkg::THR_W-1:0]         cfg_data,
  output logic                                   result_valid,
  output logic [15:0]                            best_count,
  output logic [5:0]                             best_angle,
  output logic [9:0]                             best_radius,
  output logic signed [26:0]                     best_position_sum,
  output logic signed [10:0]                     best_position_min,
  output logic signed [10:0]                     best_position_max
);
  localparam int ANGLES = hla_pkg::ANGLES_DEF;
  localparam int RAD_W = $clog2(RADII);
  localparam int ANG_W = $clog2(ANGLES);
  localparam int WAIT_W = $clog2(RADII + ANGLES + 8);

  hla_pkg::state_t state, state_next;
  logic [hla_pkg::THR_W-1:0] thresh;
  hla_pkg::tok_t tok [0:ANGLES];
  logic [ANGLES-1:0] hit;
  logic [hla_pkg::CNT_W-1:0] hit_count [0:ANGLES-1];
  logic [RAD_W-1:0] hit_radius [0:ANGLES-1];
  logic [hla_pkg::CELL_W-1:0] rep_data [0:ANGLES-1];
  logic [WAIT_W-1:0] wait_cnt, wait_cnt_next;
  logic [hla_pkg::CNT_W-1:0] top_count;
  logic [ANG_W-1:0] top_angle;
  logic [RAD_W-1:0] top_radius;
  logic accept, tok_clr, rep_vld;
  hla_pkg::mode_t md;

  assign md = hla_pkg::mode_t'(mode);
  assign busy = (state != hla_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= hla_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= cfg_data;
    end
  end

  always_comb begin
    tok[0] = '0;
    tok[0].vld = accept && md != hla_pkg::MODE_NONE;
    tok[0].clr = md == hla_pkg::MODE_CLEAR;
    tok[0].vert = md == hla_pkg::MODE_VERT;
    tok[0].row = pixel_row;
    tok[0].col = pixel_col;
  end

  // reset clears like a clear command
  assign tok_clr = accept && md == hla_pkg::MODE_CLEAR;

  for (genvar g = 0; g < ANGLES; g++) begin : g_cell
    hla_cell #(.ANGLE(g), .RADII(RADII), .RAD_W(RAD_W)) u_cell (
      .clk(clk), .rst(rst), .thresh(thresh), .tok_in(tok[g]), .tok_out(tok[g+1]),
      .hit(hit[g]), .hit_count(hit_count[g]), .hit_radius(hit_radius[g]),
      .rep_addr(top_radius), .rep_data(rep_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hla_pkg::ST_INIT;
      wait_cnt <= WAIT_W'(RADII + 2);
    end else begin
      state <= state_next;
      wait_cnt <= wait_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    wait_cnt_next = wait_cnt;
    rep_vld = 1'b0;
    case (state)
      hla_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (md == hla_pkg::MODE_CLEAR) ? hla_pkg::ST_CLEAR : hla_pkg::ST_VOTE;
          wait_cnt_next = (md == hla_pkg::MODE_CLEAR) ? WAIT_W'(RADII + 2)
                                                       : WAIT_W'(ANGLES + 2);
        end
      end
      // clearing pass after reset; no result beat
      hla_pkg::ST_INIT: begin
        if (wait_cnt == '0) begin
          state_next = hla_pkg::ST_IDLE;
        end else begin
          wait_cnt_next = wait_cnt - 1'b1;
        end
      end
      hla_pkg::ST_CLEAR, hla_pkg::ST_VOTE: begin
        if (wait_cnt == '0) begin
          state_next = hla_pkg::ST_REPORT;
        end else begin
          wait_cnt_next = wait_cnt - 1'b1;
        end
      end
      hla_pkg::ST_REPORT: begin
        // RAM read of the best cell lands this cycle
        rep_vld = 1'b1;
        state_next = hla_pkg::ST_IDLE;
      end
      default: state_next = hla_pkg::ST_IDLE;
    endcase
  end

  // hits arrive in ascending angle order, one cell a cycle
  always_ff @(posedge clk) begin
    if (rst || tok_clr) begin
      top_count <= '0;
      top_angle <= '0;
      top_radius <= '0;
    end else begin
      for (int k = 0; k < ANGLES; k++) begin
        if (hit[k] && hit_count[k] > top_count) begin
          top_count <= hit_count[k];
          top_angle <= ANG_W'(k);
          top_radius <= hit_radius[k];
        end
      end
    end
  end

  logic [hla_pkg::CELL_W-1:0] sel;
  assign sel = rep_data[top_angle];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rep_vld;
    end
    if (top_count == '0) begin
      best_count <= '0;
      best_angle <= '0;
      best_radius <= '0;
      best_position_sum <= '0;
      best_position_min <= '0;
      best_position_max <= '0;
    end else begin
      best_count <= top_count;
      best_angle <= 6'(top_angle);
      best_radius <= 10'(top_radius);
      best_position_sum <= sel[2*hla_pkg::POS_W +: hla_pkg::SUM_W];
      best_position_min <= sel[hla_pkg::POS_W +: hla_pkg::POS_W];
      best_position_max <= sel[0 +: hla_pkg::POS_W];
    end
  end

`ifndef SYNTHESIS
  a_strobe_once: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("double result strobe");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("not busy after accept");
  a_zero_best: assert property (@(posedge clk) disable iff (rst)
    (result_valid && best_count == '0) |-> best_position_sum == '0)
    else $error("empty best cell has data");
`endif
endmodule
`default_nettype wire

@@ test/hough_line_accumulator_tb.sv @@
// Self-checking testbench for hough_line_accumulator: a directed table, then random
// pixel, mode 3 and clear beats under several thresholds. Needs hla_pkg and the RTL.
`default_nettype none
module hough_line_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NANG = 36;
  localparam int NRAD = 1024;
  localparam int SCALE = 65536;
  // first-quadrant cosine magnitudes, 10 degree steps, scaled and truncated
  localparam int COS_Q [0:9] = '{65536, 64540, 61583, 56755, 50203,
                                 42125, 32768, 22414, 11380, 0};

  typedef struct packed {
    logic [15:0]        count;
    logic [5:0]         angle;
    logic [9:0]         radius;
    logic signed [26:0] psum;
    logic signed [10:0] pmin;
    logic signed [10:0] pmax;
  } line_stats_t;

  typedef struct {
    hla_pkg::mode_t md;
    int             row;
    int             col;
    bit             typed;
    line_stats_t    stats;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] mode = hla_pkg::MODE_NONE;
  logic [8:0] pixel_row = '0;
  logic [8:0] pixel_col = '0;
  logic cfg_valid = 1'b0;
  logic [hla_pkg::THR_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, result_valid;
  logic [15:0] best_count;
  logic [5:0] best_angle;
  logic [9:0] best_radius;
  logic signed [26:0] best_position_sum;
  logic signed [10:0] best_position_min, best_position_max;

  hough_line_accumulator i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .pixel_row(pixel_row), .pixel_col(pixel_col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .best_count(best_count), .best_angle(best_angle),
    .best_radius(best_radius), .best_position_sum(best_position_sum),
    .best_position_min(best_position_min), .best_position_max(best_position_max)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

  // predictor state
  int unsigned votes [NANG][NRAD];
  logic signed [26:0] pos_sum [NANG][NRAD];
  logic signed [10:0] pos_lo [NANG][NRAD];
  logic signed [10:0] pos_hi [NANG][NRAD];
  int unsigned lead_count, lead_angle, lead_radius;
  int unsigned skip_thresh;

  line_stats_t pending_stats [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_clears = 0;

  function automatic int cos_at(int a);
    if (a <= 9) return COS_Q[a];
    if (a <= 18) return -COS_Q[18 - a];
    if (a <= 27) return -COS_Q[a - 18];
    return COS_Q[36 - a];
  endfunction

  function automatic int sin_at(int a);
    return cos_at((a + 27) % NANG);
  endfunction

  task automatic wipe_cells();
    for (int a = 0; a < NANG; a++)
      for (int r = 0; r < NRAD; r++) begin
        votes[a][r] = 0;
        pos_sum[a][r] = '0;
        pos_lo[a][r] = 11'sd1023;
        pos_hi[a][r] = -11'sd1024;
      end
    lead_count = 0;
    lead_angle = 0;
    lead_radius = 0;
  endtask

  task automatic cast_votes(input hla_pkg::mode_t md, input int row, input int col);
    longint c, s, rad, pos;
    int mag;
    for (int a = 0; a < NANG; a++) begin
      c = cos_at(a);
      s = sin_at(a);
      mag = int'((md == hla_pkg::MODE_HORIZ) ? s : c);
      if (mag < 0) mag = -mag;
      if (mag < skip_thresh) continue;
      rad = (c * row + s * col) / SCALE;
      pos = (c * col - s * row) / SCALE;
      if (rad < 0 || rad >= NRAD) continue;
      if (votes[a][rad] == 65535) continue;
      votes[a][rad]++;
      if (votes[a][rad] > lead_count) begin
        lead_count = votes[a][rad];
        lead_angle = a;
        lead_radius = 32'(rad);
      end
      pos_sum[a][rad] = pos_sum[a][rad] + 27'(pos);
      if (pos > pos_hi[a][rad]) pos_hi[a][rad] = 11'(pos);
      if (pos < pos_lo[a][rad]) pos_lo[a][rad] = 11'(pos);
    end
  endtask

  function automatic line_stats_t best_line();
    line_stats_t b;
    b = '0;
    if (lead_count != 0) begin
      b.count = lead_count[15:0];
      b.angle = lead_angle[5:0];
      b.radius = lead_radius[9:0];
      b.psum = pos_sum[lead_angle][lead_radius];
      b.pmin = pos_lo[lead_angle][lead_radius];
      b.pmax = pos_hi[lead_angle][lead_radius];
    end
    return b;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] result %0d: %s got %0d expected %0d", $realtime, n_results,
             what, got, want);
  endtask

  // results are strobed for one cycle, so sample on every edge
  always @(posedge clk) begin
    line_stats_t w;
    if (!rst && result_valid) begin
      n_results++;
      if (pending_stats.size() == 0) begin
        report("unexpected beat, count", best_count, 0);
      end else begin
        w = pending_stats.pop_front();
        if (best_count !== w.count) report("best_count", best_count, w.count);
        if (best_angle !== w.angle) report("best_angle", best_angle, w.angle);
        if (best_radius !== w.radius) report("best_radius", best_radius, w.radius);
        if (best_position_sum !== w.psum)
          report("best_position_sum", best_position_sum, w.psum);
        if (best_position_min !== w.pmin)
          report("best_position_min", best_position_min, w.pmin);
        if (best_position_max !== w.pmax)
          report("best_position_max", best_position_max, w.pmax);
      end
    end
  end

  task automatic send_beat(input hla_pkg::mode_t md, input int row, input int col,
                           input bit typed, input line_stats_t typed_stats);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= md;
    pixel_row <= row[8:0];
    pixel_col <= col[8:0];
    do @(posedge clk); while (busy);
    if (md == hla_pkg::MODE_CLEAR) begin
      wipe_cells();
      n_clears++;
    end else if (md != hla_pkg::MODE_NONE) begin
      cast_votes(md, row, col);
    end
    pending_stats.push_back(typed ? typed_stats : best_line());
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_stats.size() != 0 || busy);
  endtask

  task automatic write_thresh(input int unsigned v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v[hla_pkg::THR_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    skip_thresh = v & 32'h1FFFF;
  endtask

  // corners, rows 100-103 and columns 0/7/14/21 recur so that cells pile up real counts
  task automatic random_beats(input int n);
    hla_pkg::mode_t md;
    int r, c, k, pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) md = hla_pkg::MODE_CLEAR;
      else if (pick < 5) md = hla_pkg::MODE_NONE;
      else md = pick[0] ? hla_pkg::MODE_HORIZ : hla_pkg::MODE_VERT;
      k = $urandom_range(0, 3);
      if (k == 0) begin
        r = $urandom_range(0, 511);
        c = $urandom_range(0, 511);
      end else if (k == 1) begin
        r = $urandom_range(100, 103);
        c = $urandom_range(0, 511);
      end else if (k == 2) begin
        r = $urandom_range(0, 511);
        c = 7 * $urandom_range(0, 3);
      end else begin
        r = ($urandom_range(0, 1)) ? 0 : 511;
        c = ($urandom_range(0, 1)) ? 511 : 0;
      end
      if ($urandom_range(0, 199) == 0) drain();
      send_beat(md, r, c, 1'b0, '0);
    end
  endtask

  stim_row_t dir_rows [$];
  line_stats_t none_voted;

  initial begin
    none_voted = '0;
    skip_thresh = hla_pkg::THRESH_RESET;
    wipe_cells();
    dir_rows = '{
      '{hla_pkg::MODE_NONE,  0,   0,   1'b1, none_voted},   // after reset: empty grid
      '{hla_pkg::MODE_CLEAR, 511, 511, 1'b1, none_voted},
      '{hla_pkg::MODE_HORIZ, 0,   0,   1'b0, none_voted},
      '{hla_pkg::MODE_VERT,  0,   0,   1'b0, none_voted},
      '{hla_pkg::MODE_HORIZ, 0,   1,   1'b0, none_voted},   // tiny negative radius -> 0
      '{hla_pkg::MODE_VERT,  1,   0,   1'b0, none_voted},
      '{hla_pkg::MODE_HORIZ, 511, 511, 1'b0, none_voted},
      '{hla_pkg::MODE_VERT,  511, 511, 1'b0, none_voted},
      '{hla_pkg::MODE_HORIZ, 0,   511, 1'b0, none_voted},   // many negative radii dropped
      '{hla_pkg::MODE_VERT,  511, 0,   1'b0, none_voted},
      '{hla_pkg::MODE_HORIZ, 340, 170, 1'b0, none_voted},
      '{hla_pkg::MODE_VERT,  170, 341, 1'b0, none_voted},
      '{hla_pkg::MODE_NONE,  511, 511, 1'b0, none_voted},
      '{hla_pkg::MODE_HORIZ, 0,   0,   1'b0, none_voted},
      '{hla_pkg::MODE_CLEAR, 0,   0,   1'b1, none_voted},
      '{hla_pkg::MODE_NONE,  85,  426, 1'b1, none_voted},
      '{hla_pkg::MODE_VERT,  256, 256, 1'b0, none_voted},
      '{hla_pkg::MODE_VERT,  256, 256, 1'b0, none_voted}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_beat(dir_rows[i].md, dir_rows[i].row, dir_rows[i].col,
                dir_rows[i].typed, dir_rows[i].stats);

    write_thresh(0);
    random_beats(150);
    write_thresh(131071);          // above full scale: nothing votes
    random_beats(20);
    write_thresh(65537);
    random_beats(10);
    write_thresh(65536);
    random_beats(100);
    write_thresh($urandom_range(0, 65536));
    random_beats(270);
    write_thresh(11380);
    random_beats(300);
    write_thresh(hla_pkg::THRESH_RESET);
    random_beats(300);

    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d beats (%0d clears) over 8 threshold settings, %0d results checked.",
             n_items, n_clears, n_results);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
